FILE: sv/ttcpe_pkg.sv
// Package for the two-color tile pattern encoder.
// Holds field widths, limits and the input and result transaction types.
// No dependencies.
package ttcpe_pkg;

    localparam int PIX_W          = 4;
    localparam int NUM_PIX        = 8;
    localparam int BYTE_W         = 8;
    localparam int ADDR_W         = 13;
    localparam int COUNT_W        = 10;
    localparam int TBL_W          = 2;
    localparam int LINE_SEL_W     = 3;
    localparam int TABLE_SHIFT    = 11;
    localparam int MAX_TABLES_DEF = 3;

    localparam logic [TBL_W-1:0]   NUM_TABLES_RST = 2'd3;
    localparam logic [COUNT_W-1:0] WRONG_LIMIT    = 10'd768;

    typedef logic [PIX_W-1:0] t_pixel;

    typedef struct packed {
        logic   frame_start;
        t_pixel pixel_0;
        t_pixel pixel_1;
        t_pixel pixel_2;
        t_pixel pixel_3;
        t_pixel pixel_4;
        t_pixel pixel_5;
        t_pixel pixel_6;
        t_pixel pixel_7;
    } t_line_in;

    typedef struct packed {
        logic [ADDR_W-1:0]  table_address;
        logic [BYTE_W-1:0]  pattern_byte;
        logic [BYTE_W-1:0]  color_byte;
        logic [BYTE_W-1:0]  bad_pixels;
        logic               tile_done;
        logic               tile_wrong;
        logic [COUNT_W-1:0] wrong_count;
        logic               frame_done;
    } t_line_out;

endpackage

FILE: sv/ttcpe_ifs.sv
// Valid/ready channel interfaces for the two-color tile pattern encoder.
// Depends on ttcpe_pkg for the payload types.
interface ttcpe_in_if import ttcpe_pkg::*; ();
    logic     valid;
    logic     ready;
    t_line_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ttcpe_out_if import ttcpe_pkg::*; ();
    logic      valid;
    logic      ready;
    t_line_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ttcpe_cfg_if import ttcpe_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [TBL_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/tile_two_color_pattern_encoder_top.sv
// Two-color tile pattern encoder: one 8-pixel tile line in, one encoded line out.
// Each line passes through the input register and then the result register before its
// result transaction is offered. Throughput: one line per cycle, limited only by the
// output side taking results. Reset clears the line counter, tile flag, wrong tile
// count and both pipeline valids, and sets the table count to 3.
// Depends on ttcpe_pkg and the channel interfaces in ttcpe_ifs.sv.
module tile_two_color_pattern_encoder_top
    import ttcpe_pkg::*;
#(
    parameter int MAX_TABLES = MAX_TABLES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ttcpe_cfg_if.sink    i_cfg,
    ttcpe_in_if.sink     i_in,
    ttcpe_out_if.source  o_out
);

    localparam logic [TBL_W-1:0] MaxTab = TBL_W'(MAX_TABLES);

    logic [TBL_W-1:0]   r_num_tables;
    logic               r_in_valid;
    t_line_in           r_in;
    logic               r_out_valid;
    t_line_out          r_out;
    logic [ADDR_W-1:0]  r_line;
    logic               r_tile_bad;
    logic [COUNT_W-1:0] r_wrong;

    logic               advance;
    t_pixel             px [NUM_PIX];
    t_pixel             bg;
    t_pixel             fg;
    logic [BYTE_W-1:0]  pattern;
    logic [BYTE_W-1:0]  bad;
    logic [TBL_W-1:0]   tables_used;
    logic [ADDR_W-1:0]  last_addr;
    logic [ADDR_W-1:0]  addr;
    logic               cur_bad;
    logic [COUNT_W-1:0] cur_wrong;
    logic               done;
    logic               fdone;
    logic               wrong;
    t_line_out          n_out;
    logic [ADDR_W-1:0]  n_line;
    logic               n_tile_bad;
    logic [COUNT_W-1:0] n_wrong;

    assign i_cfg.ready = 1'b1;
    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign px[0] = r_in.pixel_0;
    assign px[1] = r_in.pixel_1;
    assign px[2] = r_in.pixel_2;
    assign px[3] = r_in.pixel_3;
    assign px[4] = r_in.pixel_4;
    assign px[5] = r_in.pixel_5;
    assign px[6] = r_in.pixel_6;
    assign px[7] = r_in.pixel_7;
    assign bg    = px[0];

    // The foreground is the leftmost pixel that differs from the background.
    always_comb begin
        fg = '0;
        for (int x = NUM_PIX - 1; x > 0; x--) begin
            if (px[x] != bg) begin
                fg = px[x];
            end
        end
    end

    always_comb begin
        for (int x = 0; x < NUM_PIX; x++) begin
            pattern[NUM_PIX-1-x] = (px[x] != bg);
            bad[NUM_PIX-1-x]     = (px[x] != bg) && (px[x] != fg);
        end
    end

    always_comb begin
        tables_used = r_num_tables;
        if (tables_used == '0) begin
            tables_used = TBL_W'(1);
        end
        if (tables_used > MaxTab) begin
            tables_used = MaxTab;
        end
    end

    assign last_addr = {tables_used, {TABLE_SHIFT{1'b0}}} - ADDR_W'(1);

    // A frame start line sees all running state as cleared.
    assign addr      = r_in.frame_start ? '0 : r_line;
    assign cur_bad   = r_in.frame_start ? 1'b0 : r_tile_bad;
    assign cur_wrong = r_in.frame_start ? '0 : r_wrong;

    assign done  = (addr[LINE_SEL_W-1:0] == {LINE_SEL_W{1'b1}});
    assign fdone = (addr >= last_addr);
    assign wrong = done && (cur_bad || (bad != '0));

    always_comb begin
        n_wrong = cur_wrong;
        if (wrong && (cur_wrong < WRONG_LIMIT)) begin
            n_wrong = cur_wrong + COUNT_W'(1);
        end

        n_out.table_address = addr;
        n_out.pattern_byte  = pattern;
        n_out.color_byte    = {fg, bg};
        n_out.bad_pixels    = bad;
        n_out.tile_done     = done;
        n_out.tile_wrong    = wrong;
        n_out.wrong_count   = n_wrong;
        n_out.frame_done    = fdone;

        n_tile_bad = done ? 1'b0 : (cur_bad || (bad != '0));
        n_line     = addr + ADDR_W'(1);
        if (fdone) begin
            n_line     = '0;
            n_tile_bad = 1'b0;
            n_wrong    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_tables <= NUM_TABLES_RST;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_line       <= '0;
            r_tile_bad   <= 1'b0;
            r_wrong      <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_num_tables <= i_cfg.data;
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_line      <= n_line;
                r_tile_bad  <= n_tile_bad;
                r_wrong     <= n_wrong;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: tb/sv/tile_two_color_pattern_encoder_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for tile_two_color_pattern_encoder_top.
// Predicts every encoded line from its own model of the encoder and checks results in order.
// Depends on ttcpe_pkg, the channel interfaces in ttcpe_ifs.sv and the encoder RTL.

class encoded_line_tracker;
    ttcpe_pkg::t_line_out                   pending_lines[$];
    logic [ttcpe_pkg::ADDR_W-1:0]           next_addr;
    logic                                   tile_has_bad;
    logic [ttcpe_pkg::COUNT_W-1:0]          wrong_tiles;
    logic [ttcpe_pkg::TBL_W-1:0]            table_count;
    int                                     errors;
    int                                     results_seen;

    function new();
        next_addr    = '0;
        tile_has_bad = 1'b0;
        wrong_tiles  = '0;
        table_count  = ttcpe_pkg::NUM_TABLES_RST;
        errors       = 0;
        results_seen = 0;
    endfunction

    function void set_table_count(logic [ttcpe_pkg::TBL_W-1:0] value);
        table_count = value;
    endfunction

    // Encodes one accepted line and advances the position and wrong tile state.
    function void note_line(ttcpe_pkg::t_line_in line_in);
        ttcpe_pkg::t_pixel             px [ttcpe_pkg::NUM_PIX];
        ttcpe_pkg::t_pixel             bg;
        ttcpe_pkg::t_pixel             fg;
        logic                          have_fg;
        logic [ttcpe_pkg::BYTE_W-1:0]  pattern;
        logic [ttcpe_pkg::BYTE_W-1:0]  bad;
        int unsigned                   used;
        int unsigned                   last_addr;
        ttcpe_pkg::t_line_out          res;

        px[0] = line_in.pixel_0;
        px[1] = line_in.pixel_1;
        px[2] = line_in.pixel_2;
        px[3] = line_in.pixel_3;
        px[4] = line_in.pixel_4;
        px[5] = line_in.pixel_5;
        px[6] = line_in.pixel_6;
        px[7] = line_in.pixel_7;

        if (line_in.frame_start) begin
            next_addr    = '0;
            tile_has_bad = 1'b0;
            wrong_tiles  = '0;
        end

        bg      = px[0];
        fg      = '0;
        have_fg = 1'b0;
        pattern = '0;
        bad     = '0;
        for (int x = 0; x < ttcpe_pkg::NUM_PIX; x++) begin
            if (px[x] != bg) begin
                pattern[7-x] = 1'b1;
                if (!have_fg) begin
                    fg      = px[x];
                    have_fg = 1'b1;
                end
                if (px[x] != fg) begin
                    bad[7-x] = 1'b1;
                end
            end
        end

        // A table count of zero behaves as one table.
        used = (table_count == 0) ? 1 : table_count;
        if (used > ttcpe_pkg::MAX_TABLES_DEF) begin
            used = ttcpe_pkg::MAX_TABLES_DEF;
        end
        last_addr = used * (1 << ttcpe_pkg::TABLE_SHIFT) - 1;

        res               = '0;
        res.table_address = next_addr;
        res.pattern_byte  = pattern;
        res.color_byte    = {fg, bg};
        res.bad_pixels    = bad;
        res.tile_done     = (next_addr[ttcpe_pkg::LINE_SEL_W-1:0] == '1);
        res.frame_done    = (next_addr >= last_addr);

        if (bad != 0) begin
            tile_has_bad = 1'b1;
        end
        if (res.tile_done) begin
            res.tile_wrong = tile_has_bad;
            if (tile_has_bad && wrong_tiles < ttcpe_pkg::WRONG_LIMIT) begin
                wrong_tiles++;
            end
            tile_has_bad = 1'b0;
        end
        res.wrong_count = wrong_tiles;
        pending_lines.push_back(res);

        // The end of the frame, or a counter already past it, starts a new frame.
        if (res.frame_done) begin
            next_addr    = '0;
            tile_has_bad = 1'b0;
            wrong_tiles  = '0;
        end else begin
            next_addr = next_addr + 1'b1;
        end
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 40) begin
            $display("%0t: mismatch: %s", $time, msg);
        end
    endtask

    task check_field(string name, logic [15:0] got_v, logic [15:0] want_v);
        if (got_v !== want_v) begin
            report($sformatf("result %0d %s got %0h expected %0h",
                             results_seen, name, got_v, want_v));
        end
    endtask

    task check_line(ttcpe_pkg::t_line_out got);
        ttcpe_pkg::t_line_out want;

        results_seen++;
        if (pending_lines.size() == 0) begin
            report($sformatf("result %0d arrived with no line waiting", results_seen));
        end else begin
            want = pending_lines.pop_front();
            check_field("table_address", got.table_address, want.table_address);
            check_field("pattern_byte", got.pattern_byte, want.pattern_byte);
            check_field("color_byte", got.color_byte, want.color_byte);
            check_field("bad_pixels", got.bad_pixels, want.bad_pixels);
            check_field("tile_done", got.tile_done, want.tile_done);
            check_field("tile_wrong", got.tile_wrong, want.tile_wrong);
            check_field("wrong_count", got.wrong_count, want.wrong_count);
            check_field("frame_done", got.frame_done, want.frame_done);
        end
    endtask
endclass

module tile_two_color_pattern_encoder_top_tb;
    import ttcpe_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int NUM_DIRECTED = 19;

    // Frame start flag in the top bit, then pixel_0 down to pixel_7 one nibble each.
    localparam logic [32:0] DIRECTED_LINES [NUM_DIRECTED] = '{
        33'h1_0000_0000,  // frame start on a flat line of color 0
        33'h0_FFFF_FFFF,
        33'h0_F000_0000,  // foreground 0 against background 15
        33'h0_0FFF_FFFF,
        33'h0_0101_0101,
        33'h0_3A33_3333,
        33'h0_5555_555C,  // the only differing pixel is the rightmost one
        33'h0_1234_5678,  // many bad pixels, closes a wrong tile
        33'h0_A5A5_A5A5,
        33'h0_8999_9999,
        33'h0_2222_222B,
        33'h0_C0C0_C0C7,  // one bad pixel at the right edge
        33'h0_EEEE_EEEE,
        33'h0_6F6F_6F6F,
        33'h0_9600_0000,
        33'h0_4444_4444,  // closes the second wrong tile
        33'h1_7E7E_7E71,  // frame start clears position and count
        33'h0_0000_0000,
        33'h1_1313_1313
    };

    logic i_clk;
    logic i_rst_n;

    ttcpe_cfg_if cfg_if ();
    ttcpe_in_if  in_if ();
    ttcpe_out_if out_if ();

    encoded_line_tracker tracker;
    int cycle_count = 0;
    int stall_left = 0;
    bit in_steady = 1'b0;
    bit out_steady = 1'b0;

    tile_two_color_pattern_encoder_top #(
        .MAX_TABLES(MAX_TABLES_DEF)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_if),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Mostly back to back, sometimes a short gap, now and then a long pause.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 16);
    endfunction

    // Builds a line from a background and a foreground color. With bad_pct percent
    // a third color lands after the first foreground pixel; some lines are flat
    // and some are entirely random.
    function automatic t_line_in random_line(int bad_pct, int fs_pct);
        t_pixel   px [NUM_PIX];
        t_pixel   bg;
        t_pixel   fg;
        t_pixel   odd;
        int       r;
        int       j;
        int       k;
        t_line_in li;

        bg = t_pixel'($urandom_range(0, 15));
        fg = bg ^ t_pixel'($urandom_range(1, 15));
        r  = $urandom_range(0, 99);
        for (int x = 0; x < NUM_PIX; x++) begin
            px[x] = $urandom_range(0, 1) ? fg : bg;
        end
        px[0] = bg;
        if (r < bad_pct) begin
            j   = $urandom_range(2, NUM_PIX - 1);
            k   = $urandom_range(1, j - 1);
            odd = t_pixel'($urandom_range(0, 15));
            while (odd == bg || odd == fg) begin
                odd = t_pixel'($urandom_range(0, 15));
            end
            px[k] = fg;
            px[j] = odd;
        end else if (r < bad_pct + 10) begin
            for (int x = 0; x < NUM_PIX; x++) begin
                px[x] = bg;
            end
        end else if (r < bad_pct + 20) begin
            for (int x = 0; x < NUM_PIX; x++) begin
                px[x] = t_pixel'($urandom_range(0, 15));
            end
        end

        li.frame_start = ($urandom_range(0, 99) < fs_pct);
        li.pixel_0     = px[0];
        li.pixel_1     = px[1];
        li.pixel_2     = px[2];
        li.pixel_3     = px[3];
        li.pixel_4     = px[4];
        li.pixel_5     = px[5];
        li.pixel_6     = px[6];
        li.pixel_7     = px[7];
        return li;
    endfunction

    // Valid stays high across back-to-back transactions; it drops for a gap or when a run of lines ends.
    task automatic send_line(input t_line_in li);
        int gap;
        gap = in_steady ? 0 : idle_len();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= li;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        tracker.note_line(li);
    endtask

    task automatic send_random(int count, int bad_pct, int fs_pct, bit new_frame);
        t_line_in li;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 49) == 0) begin
                in_steady = !in_steady;
            end
            li = random_line(bad_pct, fs_pct);
            if (n == 0 && new_frame) begin
                li.frame_start = 1'b1;
            end
            send_line(li);
        end
        in_if.valid <= 1'b0;
    endtask

    // Every line gives a result, so an empty queue means the encoder is idle.
    task automatic write_table_count(input logic [TBL_W-1:0] value);
        while (tracker.pending_lines.size() != 0) @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        tracker.set_table_count(value);
    endtask

    always @(posedge i_clk) begin
        if ($urandom_range(0, 99) == 0) begin
            out_steady = !out_steady;
        end
        if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            out_if.ready <= 1'b1;
            if (!out_steady) begin
                stall_left = idle_len();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            tracker.check_line(out_if.data);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        tracker      = new();
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        out_if.ready = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lines run with the table count left at its reset value.
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_line(t_line_in'(DIRECTED_LINES[i]));
        end
        in_if.valid <= 1'b0;

        // Change the table count between runs while the position keeps counting.
        write_table_count(2'd2);
        send_random(180, 25, 0, 1'b0);
        write_table_count(2'd1);
        send_random(180, 25, 0, 1'b0);
        // Zero tables behaves as one.
        write_table_count(2'd0);
        send_random(180, 25, 0, 1'b0);

        // A new frame where every tile is wrong, so the count climbs on each tile.
        write_table_count(2'd3);
        send_random(200, 100, 0, 1'b1);

        // Mixed content with occasional frame starts under random table counts.
        for (int p = 0; p < 5; p++) begin
            write_table_count(TBL_W'($urandom_range(0, 3)));
            send_random(40, 30, 2, 1'b0);
        end

        while (tracker.pending_lines.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
